FILE: rtl/sparse_row_pattern_compressor_assert.svh
// ----------------------------------------------------------------------------
// Sparse row pattern compressor assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ROW_PATTERN_COMPRESSOR_ASSERT_SVH
`define SPARSE_ROW_PATTERN_COMPRESSOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on clk_i, held off while rst_ni is low.
`define SRPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same with an explicit clock and active-low reset.
`define SRPC_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define SRPC_ASSERT(label, prop, msg)
`define SRPC_ASSERT_CLK(label, clk, rstn, prop, msg)
`endif

`endif

FILE: rtl/srpc_pkg.sv
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and codes of the sparse row pattern compressor.
// ----------------------------------------------------------------------------
package srpc_pkg;

  // Configuration register indexes
  localparam logic CFG_FORMAT_MODE = 1'b0;
  localparam logic CFG_ACTIVE_ROWS = 1'b1;

  // Format mode codes (code 3 behaves as zero-based)
  localparam logic [1:0] MODE_OFFDIAG  = 2'd0;
  localparam logic [1:0] MODE_ONE_BASE = 2'd1;
  localparam logic [1:0] MODE_ZERO_BASE = 2'd2;

  // Per-cycle command to the cell chain
  typedef struct packed {
    logic insert;  // place the incoming column in sorted order
    logic shift;   // move every cell's value one place toward cell 0
  } cell_ctrl_t;

endpackage

FILE: rtl/srpc_cell.sv
// ----------------------------------------------------------------------------
// srpc_cell
// One slot of the sorted row buffer: compare, take from neighbor, hold.
// ----------------------------------------------------------------------------
module srpc_cell
  import srpc_pkg::*;
#(
  parameter int COL_BITS = 24
) (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic                occ_i,       // slot holds a kept entry
  input  logic                at_fill_i,   // slot is the first free one
  input  logic [COL_BITS-1:0] ins_i,
  input  logic [COL_BITS-1:0] prev_val_i,
  input  logic                prev_gt_i,
  input  logic [COL_BITS-1:0] next_val_i,
  output logic [COL_BITS-1:0] val_o,
  output logic                gt_o
);

  logic [COL_BITS-1:0] val_q;
  logic [COL_BITS-1:0] val_d;

  // Strictly greater, so a new equal value lands after the old ones.
  assign gt_o  = occ_i && (val_q > ins_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert && (gt_o || at_fill_i)) begin
      val_d = prev_gt_i ? prev_val_i : ins_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: rtl/srpc_chain.sv
// ----------------------------------------------------------------------------
// srpc_chain
// Row of sort cells; insertion sort on entry, drains through cell 0.
// ----------------------------------------------------------------------------
`include "sparse_row_pattern_compressor_assert.svh"

module srpc_chain
  import srpc_pkg::*;
#(
  parameter  int MAX_ROW  = 32,
  parameter  int COL_BITS = 24,
  localparam int FILL_W   = $clog2(MAX_ROW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [FILL_W-1:0]   fill_i,
  input  logic [COL_BITS-1:0] ins_i,
  output logic [COL_BITS-1:0] head_o
);

  logic [COL_BITS-1:0] val [MAX_ROW];
  logic                gt  [MAX_ROW];

  for (genvar i = 0; i < MAX_ROW; i++) begin : g_cell
    logic [COL_BITS-1:0] pv;
    logic [COL_BITS-1:0] nv;
    logic                pg;

    if (i == 0) begin : g_first
      assign pv = ins_i;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = val[i-1];
      assign pg = gt[i-1];
    end

    if (i == MAX_ROW - 1) begin : g_tail
      assign nv = val[i];
    end else begin : g_body
      assign nv = val[i+1];
    end

    srpc_cell #(
      .COL_BITS (COL_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .occ_i      (fill_i > FILL_W'(i)),
      .at_fill_i  (fill_i == FILL_W'(i)),
      .ins_i      (ins_i),
      .prev_val_i (pv),
      .prev_gt_i  (pg),
      .next_val_i (nv),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign head_o = val[0];

  `SRPC_ASSERT(a_head_sorted, (fill_i >= FILL_W'(2)) |-> (val[0] <= val[1]), "chain head out of order")

endmodule

FILE: rtl/sparse_row_pattern_compressor.sv
// ----------------------------------------------------------------------------
// sparse_row_pattern_compressor
// Builds sorted compressed-row column lists with saturating row pointers.
// ----------------------------------------------------------------------------
// Column indices of a row are taken one per cycle while collecting and are
// insertion-sorted into a chain of MAX_ROW cells in that same cycle (in
// off-diagonal mode the first index of a row is discarded). The item flagged
// row_end closes the row: no further input is taken until the row has been
// emitted as a header followed by its kept columns in ascending order, one
// result per cycle out of the head cell whenever the output is not stalled.
// Entries beyond MAX_ROW are dropped and flagged in the header's overflow bit,
// as is a start pointer clamped at 0xFFFFFFFF.
`include "sparse_row_pattern_compressor_assert.svh"

module sparse_row_pattern_compressor
  import srpc_pkg::*;
#(
  parameter int MAX_ROW  = 32,
  parameter int COL_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [23:0]         cfg_wdata_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COL_BITS-1:0] column_i,
  input  logic                row_end_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                item_type_o,
  output logic [31:0]         row_start_o,
  output logic [5:0]          row_count_o,
  output logic [COL_BITS-1:0] sorted_col_o,
  output logic                overflow_o,
  output logic                last_o
);

  localparam int FILL_W = $clog2(MAX_ROW + 1);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_HEADER,
    ST_DRAIN
  } state_e;

  state_e              state_q;
  logic [1:0]          mode_q;
  logic [23:0]         nar_q;
  logic [FILL_W-1:0]   fill_q;
  logic                seen_q;
  logic                dropped_q;
  logic [31:0]         rt_q;

  logic                out_valid_q;
  logic                type_q;
  logic [31:0]         start_q;
  logic [5:0]          count_q;
  logic [COL_BITS-1:0] col_q;
  logic                ovf_q;
  logic                last_q;

  logic                in_acc;
  logic                keep;
  logic                full;
  logic                slot_free;
  cell_ctrl_t          ctrl;
  logic [COL_BITS-1:0] head;
  logic [24:0]         base;
  logic [32:0]         start_sum;
  logic [32:0]         total_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFFDIAG;
      nar_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORMAT_MODE: mode_q <= cfg_wdata_i[1:0];
        CFG_ACTIVE_ROWS: nar_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_COLLECT);
  assign in_acc     = in_valid_i && in_ready_o;
  // diagonal of the row is not kept in off-diagonal mode
  assign keep       = !((mode_q == MODE_OFFDIAG) && !seen_q);
  assign full       = (fill_q == FILL_W'(MAX_ROW));
  assign slot_free  = !out_valid_q || out_ready_i;

  assign ctrl.insert = in_acc && keep && !full;
  assign ctrl.shift  = (state_q == ST_DRAIN) && slot_free;

  always_comb begin
    case (mode_q)
      MODE_OFFDIAG:  base = {1'b0, nar_q} + 25'd1;
      MODE_ONE_BASE: base = 25'd1;
      default:       base = '0;
    endcase
  end

  assign start_sum = {1'b0, rt_q} + 33'(base);
  assign total_sum = {1'b0, rt_q} + 33'(fill_q);

  srpc_chain #(
    .MAX_ROW  (MAX_ROW),
    .COL_BITS (COL_BITS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .fill_i (fill_q),
    .ins_i  (column_i),
    .head_o (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      seen_q      <= 1'b0;
      dropped_q   <= 1'b0;
      rt_q        <= '0;
      out_valid_q <= 1'b0;
      type_q      <= 1'b0;
      start_q     <= '0;
      count_q     <= '0;
      col_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_COLLECT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            seen_q <= 1'b1;
            if (keep && full) begin
              dropped_q <= 1'b1;
            end
            if (ctrl.insert) begin
              fill_q <= fill_q + FILL_W'(1);
            end
            if (row_end_i) begin
              state_q <= ST_HEADER;
            end
          end
        end
        ST_HEADER: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            type_q      <= 1'b0;
            start_q     <= start_sum[32] ? 32'hFFFF_FFFF : start_sum[31:0];
            count_q     <= 6'(fill_q);
            col_q       <= '0;
            ovf_q       <= dropped_q || start_sum[32];
            last_q      <= (fill_q == '0);
            rt_q        <= total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
            seen_q      <= 1'b0;
            dropped_q   <= 1'b0;
            state_q     <= (fill_q == '0) ? ST_COLLECT : ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            type_q      <= 1'b1;
            start_q     <= '0;
            count_q     <= '0;
            col_q       <= head;
            ovf_q       <= 1'b0;
            last_q      <= (fill_q == FILL_W'(1));
            fill_q      <= fill_q - FILL_W'(1);
            if (fill_q == FILL_W'(1)) begin
              state_q <= ST_COLLECT;
            end
          end
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign item_type_o  = type_q;
  assign row_start_o  = start_q;
  assign row_count_o  = count_q;
  assign sorted_col_o = col_q;
  assign overflow_o   = ovf_q;
  assign last_o       = last_q;

  `SRPC_ASSERT(a_fill_bound, fill_q <= FILL_W'(MAX_ROW), "row fill beyond buffer depth")
  `SRPC_ASSERT(a_drain_done, (state_q == ST_DRAIN && slot_free && fill_q == FILL_W'(1)) |=> (state_q == ST_COLLECT && fill_q == '0), "row drain did not end cleanly")
  `SRPC_ASSERT(a_total_mono, 1'b1 |=> (rt_q >= $past(rt_q)), "running total went down")

endmodule

FILE: dv/srpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srpc_checker
// Watches the configuration port and both item channels of the sparse row
// pattern compressor, keeps its own sorted copy of the open row, predicts
// each row's header and column items and compares them with the block.
// ----------------------------------------------------------------------------
module srpc_checker
  import srpc_pkg::*;
#(
  parameter int MAX_ROW  = 32,
  parameter int COL_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [COL_BITS-1:0] column_i,
  input  logic                row_end_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                item_type_i,
  input  logic [31:0]         row_start_i,
  input  logic [5:0]          row_count_i,
  input  logic [COL_BITS-1:0] sorted_col_i,
  input  logic                overflow_i,
  input  logic                last_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic                item_type;
    logic [31:0]         row_start;
    logic [5:0]          row_count;
    logic [COL_BITS-1:0] sorted_col;
    logic                overflow;
    logic                last;
  } row_item_t;

  logic [1:0]          mode_q;
  logic [23:0]         active_rows_q;
  logic [COL_BITS-1:0] held_cols[MAX_ROW];
  int unsigned         held_fill;
  bit                  diag_seen;
  bit                  row_dropped;
  logic [31:0]         ptr_total;
  row_item_t           row_items_q[$];
  int                  fails = 0;

  task automatic note_failure(input string what, input row_item_t want,
                              input row_item_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s: expected type=%0d start=%0h count=%0d col=%0h ovf=%0d last=%0d",
               $realtime, what, want.item_type, want.row_start, want.row_count,
               want.sorted_col, want.overflow, want.last);
      $display("%0t %s:      got type=%0d start=%0h count=%0d col=%0h ovf=%0d last=%0d",
               $realtime, what, got.item_type, got.row_start, got.row_count,
               got.sorted_col, got.overflow, got.last);
    end
  endtask

  // Insert one column into the open row; on row end queue header + columns.
  task automatic take_column(input logic [COL_BITS-1:0] col, input logic rend);
    logic [32:0] base;
    logic [32:0] start;
    logic [32:0] sum;
    logic        ovf;
    int          pos;
    row_item_t   r;
    if (mode_q == MODE_OFFDIAG && !diag_seen) begin
      // diagonal is not kept in off-diagonal mode
    end else if (held_fill >= MAX_ROW) begin
      row_dropped = 1'b1;
    end else begin
      pos = held_fill;
      // equal values stay ahead of the new one
      while (pos > 0 && held_cols[pos-1] > col) begin
        held_cols[pos] = held_cols[pos-1];
        pos--;
      end
      held_cols[pos] = col;
      held_fill++;
    end
    diag_seen = 1'b1;
    if (rend) begin
      case (mode_q)
        MODE_OFFDIAG:  base = 33'(active_rows_q) + 33'd1;
        MODE_ONE_BASE: base = 33'd1;
        default:       base = 33'd0;
      endcase
      start = base + {1'b0, ptr_total};
      ovf   = row_dropped;
      if (start[32]) begin
        start = 33'h0_FFFF_FFFF;
        ovf   = 1'b1;
      end
      r           = '0;
      r.row_start = start[31:0];
      r.row_count = 6'(held_fill);
      r.overflow  = ovf;
      r.last      = (held_fill == 0);
      row_items_q.push_back(r);
      for (int i = 0; i < held_fill; i++) begin
        r            = '0;
        r.item_type  = 1'b1;
        r.sorted_col = held_cols[i];
        r.last       = (i == held_fill - 1);
        row_items_q.push_back(r);
      end
      sum       = {1'b0, ptr_total} + 33'(held_fill);
      ptr_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      held_fill   = 0;
      diag_seen   = 1'b0;
      row_dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    row_item_t got;
    row_item_t want;
    got.item_type  = item_type_i;
    got.row_start  = row_start_i;
    got.row_count  = row_count_i;
    got.sorted_col = sorted_col_i;
    got.overflow   = overflow_i;
    got.last       = last_i;
    if (row_items_q.size() == 0) begin
      note_failure("unexpected result", '0, got);
    end else begin
      want = row_items_q.pop_front();
      if (got.item_type !== want.item_type || got.row_start !== want.row_start ||
          got.row_count !== want.row_count || got.sorted_col !== want.sorted_col ||
          got.overflow !== want.overflow || got.last !== want.last) begin
        note_failure("result mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        = MODE_OFFDIAG;
      active_rows_q = '0;
      held_fill     = 0;
      diag_seen     = 1'b0;
      row_dropped   = 1'b0;
      ptr_total     = '0;
      row_items_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FORMAT_MODE) begin
          mode_q = cfg_wdata_i[1:0];
        end else begin
          active_rows_q = cfg_wdata_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_column(column_i, row_end_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= row_items_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sparse row pattern compressor: directed rows for the
// diagonal drop, duplicates, extremes, spare mode and a mode change inside a
// row, then random rows (some overfilled) under random configurations, with
// random gaps on both channels. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
  import srpc_pkg::*;

  localparam int MAX_ROW  = 32;
  localparam int COL_BITS = 24;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, acts zero-based
  localparam int DIRECTED_ITEMS = 17;
  localparam int RANDOM_ITEMS   = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = 1'b0;
  logic [23:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COL_BITS-1:0] column = '0;
  logic                row_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                item_type;
  logic [31:0]         row_start;
  logic [5:0]          row_count;
  logic [COL_BITS-1:0] sorted_col;
  logic                overflow;
  logic                last;
  int                  fail_count;
  int                  pending;

  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit          in_calm  = 1'b1;
  bit          out_calm = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sparse_row_pattern_compressor #(
    .MAX_ROW (MAX_ROW),
    .COL_BITS(COL_BITS)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .column_i    (column),
    .row_end_i   (row_end),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .item_type_o (item_type),
    .row_start_o (row_start),
    .row_count_o (row_count),
    .sorted_col_o(sorted_col),
    .overflow_o  (overflow),
    .last_o      (last)
  );

  srpc_checker #(
    .MAX_ROW (MAX_ROW),
    .COL_BITS(COL_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .column_i    (column),
    .row_end_i   (row_end),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .item_type_i (item_type),
    .row_start_i (row_start),
    .row_count_i (row_count),
    .sorted_col_i(sorted_col),
    .overflow_i  (overflow),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!out_calm && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_column(input logic [COL_BITS-1:0] col, input logic rend);
    int unsigned gap;
    gap = (!in_calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column   <= col;
    row_end  <= rend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every expected result is out, plus some slack.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [23:0] rows);
    write_reg(CFG_FORMAT_MODE, {22'd0, mode});
    write_reg(CFG_ACTIVE_ROWS, rows);
  endtask

  function automatic logic [COL_BITS-1:0] pick_column();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return COL_BITS'($urandom_range(0, 15));  // plenty of duplicates
    return COL_BITS'($urandom());
  endfunction

  task automatic send_row();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 19);
    if (r < 12)      len = $urandom_range(1, 6);
    else if (r < 16) len = $urandom_range(7, 16);
    else if (r < 19) len = $urandom_range(17, 32);
    else             len = $urandom_range(33, 38);  // overfills the row buffer, but for 33 in off-diagonal mode
    for (int i = 0; i < len; i++) begin
      send_column(pick_column(), i == len - 1);
    end
  endtask

  initial begin
    logic [1:0]  mode;
    logic [23:0] rows;
    int unsigned nrows;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // off-diagonal mode at reset values: diagonal dropped, extremes, duplicates
    send_column(24'h000005, 1'b0);
    send_column(24'hFFFFFF, 1'b0);
    send_column(24'h000000, 1'b0);
    send_column(24'h000007, 1'b0);
    send_column(24'h000007, 1'b1);
    send_column(24'h000003, 1'b1);  // row of the diagonal alone
    wait_quiet();

    set_config(MODE_ONE_BASE, 24'hFFFFFF);
    send_column(24'hABCDEF, 1'b1);
    send_column(24'h800000, 1'b0);
    send_column(24'h7FFFFF, 1'b1);
    wait_quiet();

    set_config(MODE_SPARE, 24'h000000);
    send_column(24'h000009, 1'b0);
    send_column(24'h000001, 1'b0);
    send_column(24'h000009, 1'b1);
    wait_quiet();

    // mode switched after the row's first column
    write_reg(CFG_FORMAT_MODE, {22'd0, MODE_ONE_BASE});
    send_column(24'h000004, 1'b0);
    wait_quiet();
    write_reg(CFG_FORMAT_MODE, {22'd0, MODE_OFFDIAG});
    send_column(24'h000002, 1'b0);
    send_column(24'h000003, 1'b1);
    wait_quiet();

    set_config(MODE_OFFDIAG, 24'hFFFFFF);
    send_column(24'h00000A, 1'b0);
    send_column(24'h00000B, 1'b1);
    wait_quiet();

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       rows = 24'h000000;
        1:       rows = 24'hFFFFFF;
        default: rows = 24'($urandom());
      endcase
      set_config(mode, rows);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      nrows = $urandom_range(4, 12);
      for (int i = 0; i < nrows && items_sent < DIRECTED_ITEMS + RANDOM_ITEMS; i++) begin
        send_row();
      end
      wait_quiet();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sparse_row_pattern_compressor");
    end else begin
      $display("FAIL sparse_row_pattern_compressor");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL sparse_row_pattern_compressor");
    $finish;
  end

endmodule
